// ===== rtl/ttd_pkg.sv =====
// ----------------------------------------------------------------------------
// ttd_pkg
// Shared codes and types for the texture texel decoder: texture and output
// format codes, configuration register indexes and compressed block modes.
// ----------------------------------------------------------------------------
package ttd_pkg;

  // Texture format codes (texture_format register)
  localparam logic [2:0] TF_NONE   = 3'd0;
  localparam logic [2:0] TF_A3I5   = 3'd1;
  localparam logic [2:0] TF_PAL4   = 3'd2;
  localparam logic [2:0] TF_PAL16  = 3'd3;
  localparam logic [2:0] TF_PAL256 = 3'd4;
  localparam logic [2:0] TF_BLOCK  = 3'd5;
  localparam logic [2:0] TF_A5I3   = 3'd6;
  localparam logic [2:0] TF_DIRECT = 3'd7;

  // Output packing codes (output_format register)
  localparam logic [1:0] OF_RGB6A5 = 2'd0;
  localparam logic [1:0] OF_RGBA8  = 2'd1;
  localparam logic [1:0] OF_BGRA8  = 2'd2;

  // Configuration register indexes
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 13;
  localparam logic [CFG_INDEX_W-1:0] CFG_TEX_FORMAT  = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_OUT_FORMAT  = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_COLOR0_TRN  = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_PAL_BASE    = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_WIDTH_CODE  = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] CFG_HEIGHT_CODE = 3'd5;

  // Compressed block modes (block_aux[15:14])
  localparam logic [1:0] BLK_MODE_PAL3T = 2'd0;
  localparam logic [1:0] BLK_MODE_AVG3T = 2'd1;
  localparam logic [1:0] BLK_MODE_PAL4  = 2'd2;
  localparam logic [1:0] BLK_MODE_BLEND = 2'd3;

  localparam logic [15:0] OPAQUE_BIT = 16'h8000;

  typedef logic [15:0] pal_color_t;

endpackage

// ===== rtl/ttd_channels.sv =====
// ----------------------------------------------------------------------------
// ttd channels
// Valid/ready channels of the texture texel decoder: input items and texels.
// ----------------------------------------------------------------------------
interface ttd_item_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [15:0] pal_index;
  logic [15:0] pal_color;
  logic [31:0] texture_data;
  logic [15:0] block_aux;

  modport source (
    output valid, kind, pal_index, pal_color, texture_data, block_aux,
    input  ready
  );
  modport sink (
    input  valid, kind, pal_index, pal_color, texture_data, block_aux,
    output ready
  );
endinterface

interface ttd_texel_if;
  logic        valid;
  logic        ready;
  logic [31:0] texel;
  logic [9:0]  texel_x;
  logic [9:0]  texel_y;
  logic        last;

  modport source (
    output valid, texel, texel_x, texel_y, last,
    input  ready
  );
  modport sink (
    input  valid, texel, texel_x, texel_y, last,
    output ready
  );
endinterface

// ===== rtl/ttd_palette_ram.sv =====
// ----------------------------------------------------------------------------
// ttd_palette_ram
// Palette memory: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module ttd_palette_ram import ttd_pkg::*; #(
  parameter int WORDS = 65536,
  parameter int AW    = 16
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  pal_color_t    wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output pal_color_t    rdata
);

  pal_color_t mem [0:WORDS-1];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/ttd_texel_pack.sv =====
// ----------------------------------------------------------------------------
// ttd_texel_pack
// Packs a 15-bit color and a 5-bit alpha as RGB6A5, RGBA8 or BGRA8.
// ----------------------------------------------------------------------------
module ttd_texel_pack import ttd_pkg::*; (
  input  logic [14:0] color,
  input  logic [4:0]  alpha,
  input  logic [1:0]  out_format,
  output logic [31:0] texel
);

  logic [4:0] r;
  logic [4:0] g;
  logic [4:0] b;
  logic [7:0] a8;

  always_comb begin
    r  = color[4:0];
    g  = color[9:5];
    b  = color[14:10];
    a8 = {alpha, alpha[4:2]};
    case (out_format)
      OF_RGBA8: texel = {a8, b, 3'b000, g, 3'b000, r, 3'b000};
      OF_BGRA8: texel = {a8, r, 3'b000, g, 3'b000, b, 3'b000};
      // RGB6A5, also for the unused code
      default:  texel = {3'b000, alpha, 2'b00, b, 1'b0, 2'b00, g, 1'b0, 2'b00, r, 1'b0};
    endcase
  end

endmodule

// ===== rtl/texture_texel_decoder.sv =====
// ----------------------------------------------------------------------------
// texture_texel_decoder
// Decodes texture items into packed 32-bit texels with their x/y position.
// Palette beats fill the palette RAM; texture beats are decoded by the
// configured format through the palette RAM where the format needs it.
// ----------------------------------------------------------------------------
//
// Channel  Dir  Handshake     Beat contents
// items    in   valid/ready   kind, pal_index, pal_color, texture_data, block_aux
// texels   out  valid/ready   texel, texel_x, texel_y, last
// cfg      in   cfg_we        cfg_index, cfg_data (no read-back)
//
// Per item: a palette write goes straight to the palette RAM; direct gives one
// texel; A3I5, A5I3, 256-color one palette RAM read then one texel beat;
// 16-color and 4-color one palette RAM read then one texel beat per texel; a
// compressed block four palette RAM reads, a color mix step, then one texel
// beat per cycle for 16 texels. Texel beats stall while texels.ready is low;
// the output register holds the last texel so the next item is taken
// meanwhile. Reset (rst, synchronous) clears control state, the configuration
// and the position; palette contents are undefined until written.
// ----------------------------------------------------------------------------
module texture_texel_decoder import ttd_pkg::*; #(
  parameter int PALETTE_WORDS = 65536   // power of two, 256 to 65536
) (
  input  logic                   clk,
  input  logic                   rst,
  ttd_item_if.sink               items,
  ttd_texel_if.source            texels,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam int PAL_AW = $clog2(PALETTE_WORDS);

  typedef enum logic [2:0] {
    S_IDLE,
    S_PAL_RD,
    S_PAL_OUT,
    S_BLK_RD,
    S_BLK_MIX,
    S_BLK_OUT
  } state_t;

  state_t state;

  // Configuration
  logic [2:0]  texture_format;
  logic [1:0]  output_format;
  logic        color0_transparent;
  logic [12:0] palette_base;
  logic [2:0]  width_code;
  logic [2:0]  height_code;

  // Position of the next texel (or next block's top left)
  logic [9:0] column_position;
  logic [9:0] row_position;

  // Current item
  logic [31:0] tex_data;
  logic [15:0] blk_aux;
  logic [1:0]  texel_idx;
  logic [2:0]  rd_step;
  logic [3:0]  blk_texel;
  pal_color_t  blk_color [0:3];

  // Output register
  logic        out_valid;
  logic [31:0] out_texel;
  logic [9:0]  out_x;
  logic [9:0]  out_y;
  logic        out_last;

  pal_color_t  pal_rdata;
  logic        pal_we;
  logic        pal_re;
  logic [PAL_AW-1:0] pal_raddr;

  logic        accept;
  logic        out_free;
  logic        emit;
  logic        item_last;

  logic [7:0]  byte_v;
  logic [7:0]  pal4_sh;
  logic [7:0]  pal_idx;
  logic [1:0]  texel_last;
  logic [16:0] base_texel;
  logic [16:0] addr_texel;
  logic [16:0] addr_blk;
  logic [31:0] blk_sh;
  logic [1:0]  blk_sel;
  pal_color_t  blk_c;
  logic [1:0]  cap_idx;

  logic [14:0] pk_color;
  logic [4:0]  pk_alpha;
  logic [4:0]  tx_alpha;
  logic [31:0] pk_texel;
  logic [31:0] texel_cand;
  logic [9:0]  x_cand;
  logic [9:0]  y_cand;

  logic [2:0]  dx;
  logic [2:0]  dy;
  logic [10:0] col_sum;
  logic [10:0] row_sum;
  logic [10:0] width_v;
  logic [10:0] height_v;
  logic [9:0]  col_next;
  logic [9:0]  row_next;

  // Per-channel color mixing for compressed blocks
  function automatic logic [4:0] avg5(input logic [4:0] a, input logic [4:0] b);
    logic [5:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[5:1];
  endfunction

  function automatic logic [4:0] mix53(input logic [4:0] a, input logic [4:0] b);
    logic [7:0] s;
    s = {1'b0, a, 2'b00} + {3'b000, a} + {2'b00, b, 1'b0} + {3'b000, b};
    return s[7:3];
  endfunction

  assign accept       = items.valid && items.ready;
  assign items.ready  = (state == S_IDLE);
  assign pal_we       = accept && !items.kind;

  assign out_free     = !out_valid || texels.ready;
  assign emit         = ((state == S_PAL_OUT) || (state == S_BLK_OUT)) && out_free;

  assign texels.valid   = out_valid;
  assign texels.texel   = out_texel;
  assign texels.texel_x = out_x;
  assign texels.texel_y = out_y;
  assign texels.last    = out_last;

  // Palette index of the current texel
  assign byte_v  = tex_data[7:0];
  assign pal4_sh = byte_v >> {texel_idx, 1'b0};

  always_comb begin
    case (texture_format)
      TF_PAL4:   pal_idx = {6'd0, pal4_sh[1:0]};
      TF_PAL16:  pal_idx = {4'd0, (texel_idx[0] ? byte_v[7:4] : byte_v[3:0])};
      TF_PAL256: pal_idx = byte_v;
      TF_A3I5:   pal_idx = {3'd0, byte_v[4:0]};
      TF_A5I3:   pal_idx = {5'd0, byte_v[2:0]};
      default:   pal_idx = 8'd0;
    endcase
  end

  always_comb begin
    case (texture_format)
      TF_PAL4:  texel_last = 2'd3;
      TF_PAL16: texel_last = 2'd1;
      default:  texel_last = 2'd0;
    endcase
  end

  // Alpha of the current texel in the non-block formats
  always_comb begin
    case (texture_format)
      TF_A3I5:   tx_alpha = {byte_v[7:5], byte_v[7:6]};
      TF_A5I3:   tx_alpha = byte_v[7:3];
      TF_DIRECT: tx_alpha = {5{tex_data[15]}};
      default:   tx_alpha = (color0_transparent && (pal_idx == 8'd0)) ? 5'd0 : 5'h1F;
    endcase
  end

  // Palette addresses; wrap to the RAM depth by truncation
  assign base_texel = (texture_format == TF_PAL4) ? {2'b00, palette_base, 2'b00}
                                                   : {1'b0, palette_base, 3'b000};
  assign addr_texel = base_texel + {9'd0, pal_idx};
  assign addr_blk   = {1'b0, palette_base, 3'b000} + {2'b00, blk_aux[13:0], 1'b0}
                    + {15'd0, rd_step[1:0]};

  assign pal_re    = (state == S_PAL_RD) || ((state == S_BLK_RD) && !rd_step[2]);
  assign pal_raddr = (state == S_BLK_RD) ? addr_blk[PAL_AW-1:0] : addr_texel[PAL_AW-1:0];
  assign cap_idx   = rd_step[1:0] - 2'd1;

  // Block texel color select
  assign blk_sh  = tex_data >> {blk_texel, 1'b0};
  assign blk_sel = blk_sh[1:0];
  assign blk_c   = blk_color[blk_sel];

  always_comb begin
    if (state == S_BLK_OUT) begin
      pk_color = blk_c[14:0];
      pk_alpha = 5'h1F;
    end else if (texture_format == TF_DIRECT) begin
      pk_color = tex_data[14:0];
      pk_alpha = tx_alpha;
    end else begin
      pk_color = pal_rdata[14:0];
      pk_alpha = tx_alpha;
    end
  end

  ttd_texel_pack u_pack (
    .color      (pk_color),
    .alpha      (pk_alpha),
    .out_format (output_format),
    .texel      (pk_texel)
  );

  always_comb begin
    if (state == S_BLK_OUT) begin
      // transparent block color gives an all-zero texel
      texel_cand = blk_c[15] ? pk_texel : 32'd0;
      x_cand     = column_position + {8'd0, blk_texel[1:0]};
      y_cand     = row_position + {8'd0, blk_texel[3:2]};
      item_last  = (blk_texel == 4'd15);
    end else begin
      texel_cand = pk_texel;
      x_cand     = column_position + {8'd0, texel_idx};
      y_cand     = row_position;
      item_last  = (texel_idx == texel_last);
    end
  end

  // Position advance at the end of an item
  assign dx       = (state == S_BLK_OUT) ? 3'd4 : ({1'b0, texel_last} + 3'd1);
  assign dy       = (state == S_BLK_OUT) ? 3'd4 : 3'd1;
  assign col_sum  = {1'b0, column_position} + {8'd0, dx};
  assign row_sum  = {1'b0, row_position} + {8'd0, dy};
  assign width_v  = 11'd8 << width_code;
  assign height_v = 11'd8 << height_code;

  always_comb begin
    col_next = col_sum[9:0];
    row_next = row_position;
    if (col_sum >= width_v) begin
      col_next = 10'd0;
      row_next = (row_sum >= height_v) ? 10'd0 : row_sum[9:0];
    end
  end

  ttd_palette_ram #(
    .WORDS (PALETTE_WORDS),
    .AW    (PAL_AW)
  ) u_pal_ram (
    .clk   (clk),
    .we    (pal_we),
    .waddr (items.pal_index[PAL_AW-1:0]),
    .wdata (items.pal_color),
    .re    (pal_re),
    .raddr (pal_raddr),
    .rdata (pal_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state              <= S_IDLE;
      out_valid          <= 1'b0;
      texture_format     <= TF_DIRECT;
      output_format      <= OF_RGB6A5;
      color0_transparent <= 1'b0;
      palette_base       <= '0;
      width_code         <= '0;
      height_code        <= '0;
      column_position    <= '0;
      row_position       <= '0;
    end else begin
      // drop the output beat once taken; a new texel refills it below
      if (texels.ready && !emit) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (accept && items.kind) begin
            tex_data  <= items.texture_data;
            blk_aux   <= items.block_aux;
            texel_idx <= 2'd0;
            rd_step   <= 3'd0;
            blk_texel <= 4'd0;
            case (texture_format)
              TF_NONE:   state <= S_IDLE;
              TF_BLOCK:  state <= S_BLK_RD;
              TF_DIRECT: state <= S_PAL_OUT;
              default:   state <= S_PAL_RD;
            endcase
          end
        end

        S_PAL_RD: begin
          state <= S_PAL_OUT;
        end

        S_BLK_RD: begin
          // one read issued per step, its data captured in the next step
          rd_step <= rd_step + 3'd1;
          if (rd_step != 3'd0) begin
            blk_color[cap_idx] <= pal_rdata | OPAQUE_BIT;
          end
          if (rd_step[2]) begin
            state <= S_BLK_MIX;
          end
        end

        S_BLK_MIX: begin
          case (blk_aux[15:14])
            BLK_MODE_PAL3T: begin
              blk_color[3] <= '0;
            end
            BLK_MODE_AVG3T: begin
              blk_color[2] <= {1'b1,
                               avg5(blk_color[0][14:10], blk_color[1][14:10]),
                               avg5(blk_color[0][9:5],   blk_color[1][9:5]),
                               avg5(blk_color[0][4:0],   blk_color[1][4:0])};
              blk_color[3] <= '0;
            end
            BLK_MODE_PAL4: begin
              // colors 2 and 3 come straight from the palette
            end
            default: begin
              blk_color[2] <= {1'b1,
                               mix53(blk_color[0][14:10], blk_color[1][14:10]),
                               mix53(blk_color[0][9:5],   blk_color[1][9:5]),
                               mix53(blk_color[0][4:0],   blk_color[1][4:0])};
              blk_color[3] <= {1'b1,
                               mix53(blk_color[1][14:10], blk_color[0][14:10]),
                               mix53(blk_color[1][9:5],   blk_color[0][9:5]),
                               mix53(blk_color[1][4:0],   blk_color[0][4:0])};
            end
          endcase
          state <= S_BLK_OUT;
        end

        S_PAL_OUT: begin
          if (emit) begin
            if (item_last) begin
              state <= S_IDLE;
            end else begin
              texel_idx <= texel_idx + 2'd1;
              state     <= S_PAL_RD;
            end
          end
        end

        S_BLK_OUT: begin
          if (emit) begin
            blk_texel <= blk_texel + 4'd1;
            if (item_last) begin
              state <= S_IDLE;
            end
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase

      // load the output register and advance the position
      if (emit) begin
        out_valid <= 1'b1;
        out_texel <= texel_cand;
        out_x     <= x_cand;
        out_y     <= y_cand;
        out_last  <= item_last;
        if (item_last) begin
          column_position <= col_next;
          row_position    <= row_next;
        end
      end

      // configuration writes; format and geometry changes restart the position
      if (cfg_we) begin
        case (cfg_index)
          CFG_TEX_FORMAT: begin
            texture_format  <= cfg_data[2:0];
            column_position <= '0;
            row_position    <= '0;
          end
          CFG_OUT_FORMAT: output_format      <= cfg_data[1:0];
          CFG_COLOR0_TRN: color0_transparent <= cfg_data[0];
          CFG_PAL_BASE:   palette_base       <= cfg_data;
          CFG_WIDTH_CODE: begin
            width_code      <= cfg_data[2:0];
            column_position <= '0;
            row_position    <= '0;
          end
          CFG_HEIGHT_CODE: begin
            height_code     <= cfg_data[2:0];
            column_position <= '0;
            row_position    <= '0;
          end
          default: begin
            // index beyond the register list: ignore
          end
        endcase
      end
    end
  end

endmodule

// ===== rtl/ttd_checker.sv =====
// ----------------------------------------------------------------------------
// ttd_checker
// Port-level checks on the texture texel decoder, bound to the top level.
// ----------------------------------------------------------------------------
module ttd_checker import ttd_pkg::*; (
  input logic                   clk,
  input logic                   rst,
  input logic                   in_valid,
  input logic                   in_ready,
  input logic                   in_kind,
  input logic                   out_valid,
  input logic                   out_ready,
  input logic [31:0]            texel,
  input logic [9:0]             texel_x,
  input logic [9:0]             texel_y,
  input logic                   last,
  input logic                   cfg_we,
  input logic [CFG_INDEX_W-1:0] cfg_index,
  input logic [CFG_DATA_W-1:0]  cfg_data
);

  logic [2:0] fmt_shadow;
  logic       in_beat;

  assign in_beat = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      fmt_shadow <= TF_DIRECT;
    end else if (cfg_we && (cfg_index == CFG_TEX_FORMAT)) begin
      fmt_shadow <= cfg_data[2:0];
    end
  end

  // reset empties the output register
  a_reset_clears_out: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("texel beat valid after reset");

  // a stalled texel beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(texel) && $stable(texel_x)
                                && $stable(texel_y) && $stable(last))
    else $error("stalled texel beat changed");

  // a texture item that decodes closes the intake once taken
  a_busy_after_texture: assert property (@(posedge clk) disable iff (rst)
    in_beat && in_kind && (fmt_shadow != TF_NONE) |=> !in_ready)
    else $error("intake open right after a decoding texture item");

  // palette writes and ignored texture items leave the intake open
  a_open_after_noop: assert property (@(posedge clk) disable iff (rst)
    in_beat && (!in_kind || (fmt_shadow == TF_NONE)) |=> in_ready)
    else $error("intake closed after an item with no texels");

endmodule

bind texture_texel_decoder ttd_checker u_ttd_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (items.valid),
  .in_ready  (items.ready),
  .in_kind   (items.kind),
  .out_valid (texels.valid),
  .out_ready (texels.ready),
  .texel     (texels.texel),
  .texel_x   (texels.texel_x),
  .texel_y   (texels.texel_y),
  .last      (texels.last),
  .cfg_we    (cfg_we),
  .cfg_index (cfg_index),
  .cfg_data  (cfg_data)
);

// ===== tb/ttd_texel_checker.sv =====
// ----------------------------------------------------------------------------
// ttd_texel_checker
// Watches the item, texel and configuration ports of the texture texel
// decoder, predicts the texel beats of every accepted item and compares
// each texel beat, field by field, with the oldest prediction.
// ----------------------------------------------------------------------------
module ttd_texel_checker import ttd_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  ttd_item_if                    items,
  ttd_texel_if                   texels,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  output int                     fails,
  output int                     pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [31:0] texel;
    logic [9:0]  x;
    logic [9:0]  y;
    logic        last;
  } texel_beat_t;

  texel_beat_t texels_due[$];
  pal_color_t  pal_mem [0:65535];

  logic [2:0]  tex_fmt;
  logic [1:0]  out_fmt;
  logic        c0_clear;
  logic [12:0] pal_base;
  logic [2:0]  w_code;
  logic [2:0]  h_code;
  int unsigned col_pos;
  int unsigned row_pos;

  function automatic logic [31:0] pack_texel(pal_color_t c, logic [4:0] a5);
    logic [4:0] r, g, b;
    logic [7:0] a8;
    r  = c[4:0];
    g  = c[9:5];
    b  = c[14:10];
    a8 = {a5, a5[4:2]};
    case (out_fmt)
      OF_RGBA8: return {a8, b, 3'b000, g, 3'b000, r, 3'b000};
      OF_BGRA8: return {a8, r, 3'b000, g, 3'b000, b, 3'b000};
      default:  return {3'b000, a5, 2'b00, b, 3'b000, g, 3'b000, r, 1'b0};
    endcase
  endfunction

  // weighted per-channel mix of two palette colors, truncated, opaque
  function automatic pal_color_t mix(pal_color_t c0, pal_color_t c1, int w0, int w1, int sh);
    int r, g, b;
    r = (int'(c0 & 16'h001F) * w0 + int'(c1 & 16'h001F) * w1) >> sh;
    g = ((int'(c0 & 16'h03E0) * w0 + int'(c1 & 16'h03E0) * w1) >> sh) & 'h03E0;
    b = ((int'(c0 & 16'h7C00) * w0 + int'(c1 & 16'h7C00) * w1) >> sh) & 'h7C00;
    return pal_color_t'(r | g | b) | OPAQUE_BIT;
  endfunction

  function automatic void push_texel(logic [31:0] t, int unsigned x, int unsigned y,
                                     logic last);
    texel_beat_t b;
    b.texel = t;
    b.x     = 10'(x);
    b.y     = 10'(y);
    b.last  = last;
    texels_due.push_back(b);
  endfunction

  function automatic void step_position(int unsigned dx, int unsigned dy);
    int unsigned nc, nr;
    nc = col_pos + dx;
    if (nc >= (8 << w_code)) begin
      nr = row_pos + dy;
      nc = 0;
      if (nr >= (8 << h_code)) nr = 0;
      row_pos = nr & 'h3FF;
    end
    col_pos = nc & 'h3FF;
  endfunction

  function automatic void decode_alpha_index(logic [7:0] byt, int ibits);
    int idx, a;
    idx = int'(byt) & ((1 << ibits) - 1);
    a   = int'(byt) >> ibits;
    if (ibits == 5) a = a * 4 + a / 2;
    push_texel(pack_texel(pal_mem[16'(int'(pal_base) * 8 + idx)], 5'(a)),
               col_pos, row_pos, 1'b1);
    step_position(1, 1);
  endfunction

  function automatic void decode_indexed(logic [7:0] byt, int bits);
    int n, mask, base, idx;
    logic [4:0] a5;
    n    = 8 / bits;
    mask = (1 << bits) - 1;
    base = (bits == 2) ? int'(pal_base) * 4 : int'(pal_base) * 8;
    for (int i = 0; i < n; i++) begin
      idx = (int'(byt) >> (i * bits)) & mask;
      a5  = (c0_clear && idx == 0) ? 5'd0 : 5'd31;
      push_texel(pack_texel(pal_mem[16'(base + idx)], a5),
                 col_pos + i, row_pos, i == n - 1);
    end
    step_position(n, 1);
  endfunction

  function automatic void decode_block(logic [31:0] data, logic [15:0] aux);
    int base, k;
    pal_color_t pick [4];
    pal_color_t c;
    base    = int'(pal_base) * 8 + int'(aux[13:0]) * 2;
    pick[0] = pal_mem[16'(base)] | OPAQUE_BIT;
    pick[1] = pal_mem[16'(base + 1)] | OPAQUE_BIT;
    case (aux[15:14])
      BLK_MODE_PAL3T: begin
        pick[2] = pal_mem[16'(base + 2)] | OPAQUE_BIT;
        pick[3] = '0;
      end
      BLK_MODE_AVG3T: begin
        pick[2] = mix(pick[0], pick[1], 1, 1, 1);
        pick[3] = '0;
      end
      BLK_MODE_PAL4: begin
        pick[2] = pal_mem[16'(base + 2)] | OPAQUE_BIT;
        pick[3] = pal_mem[16'(base + 3)] | OPAQUE_BIT;
      end
      default: begin
        pick[2] = mix(pick[0], pick[1], 5, 3, 3);
        pick[3] = mix(pick[0], pick[1], 3, 5, 3);
      end
    endcase
    k = 0;
    for (int j = 0; j < 4; j++) begin
      for (int i = 0; i < 4; i++) begin
        c = pick[data[2 * k +: 2]];
        push_texel(c[15] ? pack_texel(c, 5'd31) : 32'd0,
                   col_pos + i, row_pos + j, k == 15);
        k++;
      end
    end
    step_position(4, 4);
  endfunction

  function automatic void decode_item(logic [31:0] data, logic [15:0] aux);
    case (tex_fmt)
      TF_A3I5:   decode_alpha_index(data[7:0], 5);
      TF_PAL4:   decode_indexed(data[7:0], 2);
      TF_PAL16:  decode_indexed(data[7:0], 4);
      TF_PAL256: decode_indexed(data[7:0], 8);
      TF_BLOCK:  decode_block(data, aux);
      TF_A5I3:   decode_alpha_index(data[7:0], 3);
      TF_DIRECT: begin
        push_texel(pack_texel(data[15:0], data[15] ? 5'd31 : 5'd0),
                   col_pos, row_pos, 1'b1);
        step_position(1, 1);
      end
      default: ;  // no format: item is dropped, position holds
    endcase
  endfunction

  always @(posedge clk) begin
    texel_beat_t due;
    if (rst) begin
      texels_due.delete();
      tex_fmt  = TF_DIRECT;
      out_fmt  = OF_RGB6A5;
      c0_clear = 1'b0;
      pal_base = '0;
      w_code   = '0;
      h_code   = '0;
      col_pos  = 0;
      row_pos  = 0;
    end else begin
      if (texels.valid === 1'b1 && texels.ready === 1'b1) begin
        if (texels_due.size() == 0) begin
          $error("unexpected texel beat: texel %h x %0d y %0d last %b",
                 texels.texel, texels.texel_x, texels.texel_y, texels.last);
          fails++;
        end else begin
          due = texels_due.pop_front();
          if (texels.texel !== due.texel) begin
            $error("texel: expected %h, actual %h", due.texel, texels.texel);
            fails++;
          end
          if (texels.texel_x !== due.x) begin
            $error("texel_x: expected %0d, actual %0d", due.x, texels.texel_x);
            fails++;
          end
          if (texels.texel_y !== due.y) begin
            $error("texel_y: expected %0d, actual %0d", due.y, texels.texel_y);
            fails++;
          end
          if (texels.last !== due.last) begin
            $error("last: expected %b, actual %b", due.last, texels.last);
            fails++;
          end
        end
      end
      if (cfg_we === 1'b1) begin
        case (cfg_index)
          CFG_TEX_FORMAT: begin
            tex_fmt = cfg_data[2:0];
            col_pos = 0;
            row_pos = 0;
          end
          CFG_OUT_FORMAT: out_fmt  = cfg_data[1:0];
          CFG_COLOR0_TRN: c0_clear = cfg_data[0];
          CFG_PAL_BASE:   pal_base = cfg_data[12:0];
          CFG_WIDTH_CODE: begin
            w_code  = cfg_data[2:0];
            col_pos = 0;
            row_pos = 0;
          end
          CFG_HEIGHT_CODE: begin
            h_code  = cfg_data[2:0];
            col_pos = 0;
            row_pos = 0;
          end
          default: ;
        endcase
      end
      if (items.valid === 1'b1 && items.ready === 1'b1) begin
        if (items.kind == 1'b0) pal_mem[items.pal_index] = items.pal_color;
        else decode_item(items.texture_data, items.block_aux);
      end
    end
    pending = texels_due.size();
  end

endmodule

// ===== tb/texture_texel_decoder_tb.sv =====
// ----------------------------------------------------------------------------
// texture_texel_decoder_tb
// Stimulus and verdict for the texture texel decoder. Writes each palette
// entry before a texture beat uses it, runs a directed pass over every
// texture and output format and their edge values, then random phases under
// changing configuration, with random stalls on both channels. A checker
// beside the block does the comparing.
// ----------------------------------------------------------------------------
module texture_texel_decoder_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import ttd_pkg::*;

  // Register indexes past the list and the spare output packing code:
  // both must be harmless.
  localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_LO = 3'd6;
  localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_HI = 3'd7;
  localparam logic [1:0]             OF_SPARE     = 2'd3;

  localparam int SETTLE     = 40;   // covers the slowest item (compressed)
  localparam int LONG_HOLD  = 500;  // receiver hold-off, long enough to back up
  localparam int PHASES     = 11;
  localparam int PHASE_BEATS = 8;

  logic clk = 1'b0;
  logic rst;
  logic cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;
  int   fails;
  int   pending;
  logic long_hold_req;

  // configuration the sender last wrote, used to aim palette writes
  logic [2:0]  cur_tf;
  logic [12:0] cur_pb;

  // palette entries the sender has written so far
  bit pal_written [0:65535];

  ttd_item_if  item_ch ();
  ttd_texel_if texel_ch ();

  texture_texel_decoder dut (
    .clk       (clk),
    .rst       (rst),
    .items     (item_ch),
    .texels    (texel_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  ttd_texel_checker check (
    .clk       (clk),
    .rst       (rst),
    .items     (item_ch),
    .texels    (texel_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .fails     (fails),
    .pending   (pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Hard stop: far beyond the slowest legal run (every texel waiting out
  // the longest receiver gap).
  initial begin
    #10ms;
    $display("== FAIL ==");
    $finish;
  end

  // Gap length for either side: mostly none, often short, now and then long.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Palette color with the all-ones and all-zeros blend edges mixed in.
  function automatic logic [15:0] pick_color();
    int r;
    r = $urandom_range(0, 7);
    if (r == 0) return 16'hFFFF;
    if (r == 1) return 16'h0000;
    return 16'($urandom);
  endfunction

  // Drive one beat at the falling edge and hold it until the block takes it.
  // Valid stays high on return so back-to-back beats never drop it.
  task automatic send_beat(logic k, logic [15:0] idx, logic [15:0] color,
                           logic [31:0] data, logic [15:0] aux);
    @(negedge clk);
    item_ch.kind         = k;
    item_ch.pal_index    = idx;
    item_ch.pal_color    = color;
    item_ch.texture_data = data;
    item_ch.block_aux    = aux;
    item_ch.valid        = 1'b1;
    do @(posedge clk); while (item_ch.ready !== 1'b1);
  endtask

  // Unused fields carry random junk so every input bit toggles.
  task automatic send_palette(logic [15:0] idx, logic [15:0] color);
    pal_written[idx] = 1'b1;
    send_beat(1'b0, idx, color, $urandom, 16'($urandom));
  endtask

  // Write every palette entry the next texture beat reads that was never
  // written, so no color it uses comes from an unwritten entry.
  task automatic prime_reads(logic [31:0] data, logic [15:0] aux);
    int base;
    int cnt;
    int idx [4];
    base = int'(cur_pb) * 8;
    cnt  = 0;
    for (int i = 0; i < 4; i++) idx[i] = 0;
    case (cur_tf)
      TF_A3I5: begin
        idx[0] = int'(data[4:0]);
        cnt    = 1;
      end
      TF_A5I3: begin
        idx[0] = int'(data[2:0]);
        cnt    = 1;
      end
      TF_PAL4: begin
        base = int'(cur_pb) * 4;
        for (int i = 0; i < 4; i++) idx[i] = int'(data[2 * i +: 2]);
        cnt = 4;
      end
      TF_PAL16: begin
        idx[0] = int'(data[3:0]);
        idx[1] = int'(data[7:4]);
        cnt    = 2;
      end
      TF_PAL256: begin
        idx[0] = int'(data[7:0]);
        cnt    = 1;
      end
      TF_BLOCK: begin
        for (int i = 0; i < 4; i++) idx[i] = int'(aux[13:0]) * 2 + i;
        case (aux[15:14])
          BLK_MODE_PAL3T: cnt = 3;
          BLK_MODE_PAL4:  cnt = 4;
          default:        cnt = 2;
        endcase
      end
      default: cnt = 0;
    endcase
    for (int i = 0; i < cnt; i++) begin
      if (!pal_written[16'(base + idx[i])])
        send_palette(16'(base + idx[i]), pick_color());
    end
  endtask

  task automatic send_texture(logic [31:0] data, logic [15:0] aux);
    prime_reads(data, aux);
    send_beat(1'b1, 16'($urandom), 16'($urandom), data, aux);
  endtask

  // Drop valid for a gap between beats, sized by n.
  task automatic tx_gap(int n);
    if (n > 0) begin
      @(negedge clk);
      item_ch.valid = 1'b0;
      repeat (n - 1) @(negedge clk);
    end
  endtask

  // Stop offering, wait for every predicted texel, then let the block go
  // quiet in case the last item is one that yields nothing.
  task automatic drain();
    @(negedge clk);
    item_ch.valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic cfg_write(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    @(negedge clk);
    cfg_we    = 1'b0;
  endtask

  // Full reconfiguration, only once the block is idle. Unused data bits
  // above each register are random: the block must mask them.
  task automatic setup(logic [2:0] tf, logic [1:0] of, logic c0, logic [12:0] pb,
                       logic [2:0] wc, logic [2:0] hc);
    drain();
    cfg_write(CFG_TEX_FORMAT,  {10'($urandom), tf});
    cfg_write(CFG_OUT_FORMAT,  {11'($urandom), of});
    cfg_write(CFG_COLOR0_TRN,  {12'($urandom), c0});
    cfg_write(CFG_PAL_BASE,    pb);
    cfg_write(CFG_WIDTH_CODE,  {10'($urandom), wc});
    cfg_write(CFG_HEIGHT_CODE, {10'($urandom), hc});
    cfg_write($urandom_range(0, 1) ? CFG_SPARE_LO : CFG_SPARE_HI, 13'($urandom));
    cur_tf = tf;
    cur_pb = pb;
  endtask

  // Palette entry inside the window the current format mostly reads.
  function automatic logic [15:0] near_entry();
    int scale;
    scale = (cur_tf == TF_PAL4) ? 4 : 8;
    return 16'(int'(cur_pb) * scale + $urandom_range(0, 7));
  endfunction

  // Keep most palette indexes within eight entries of the base so few
  // palette writes are needed; now and then let them range freely.
  function automatic logic [31:0] narrow_data(logic [31:0] data);
    if ($urandom_range(0, 7) == 0) return data;
    case (cur_tf)
      TF_A3I5:   return data & 32'hFFFF_FFE7;
      TF_PAL16:  return data & 32'hFFFF_FF77;
      TF_PAL256: return data & 32'hFFFF_FF07;
      default:   return data;
    endcase
  endfunction

  // Texel receiver: random gaps, calm stretches, and one long hold-off on
  // request so the block backs up and stalls its input.
  initial begin : texel_sink
    int gap_left;
    int calm_left;
    bit hold_served;
    gap_left    = 0;
    calm_left   = 0;
    hold_served = 1'b0;
    texel_ch.ready = 1'b0;
    wait (rst == 1'b0);
    forever begin
      @(negedge clk);
      if (long_hold_req && !hold_served) begin
        hold_served    = 1'b1;
        texel_ch.ready = 1'b0;
        repeat (LONG_HOLD - 1) @(negedge clk);
      end else if (gap_left > 0) begin
        texel_ch.ready = 1'b0;
        gap_left--;
      end else begin
        texel_ch.ready = 1'b1;
        if (calm_left > 0) calm_left--;
        else if ($urandom_range(0, 99) == 0) calm_left = 200;
        else gap_left = pick_gap();
      end
    end
  end

  initial begin : item_source
    int r;
    bit calm;
    logic [2:0]  tf;
    logic [12:0] pb;
    logic [2:0]  wc, hc;
    logic [15:0] aux;

    rst                  = 1'b1;
    cfg_we               = 1'b0;
    cfg_index            = '0;
    cfg_data             = '0;
    long_hold_req        = 1'b0;
    cur_tf               = TF_DIRECT;
    cur_pb               = '0;
    item_ch.valid        = 1'b0;
    item_ch.kind         = 1'b0;
    item_ch.pal_index    = '0;
    item_ch.pal_color    = '0;
    item_ch.texture_data = '0;
    item_ch.block_aux    = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // ---- directed pass ----
    // Direct format after reset: black, white, alpha alone, color alone.
    send_texture(32'h0000_0000, 16'h0000);
    send_texture(32'hFFFF_FFFF, 16'hFFFF);
    send_texture(32'h0000_8000, 16'h0000);
    send_texture(32'h0000_7FFF, 16'h0000);
    setup(TF_DIRECT, OF_RGBA8, 1'b0, 13'd0, 3'd0, 3'd0);
    send_texture(32'h0000_FFFF, 16'h0000);
    send_texture(32'h0000_7C1F, 16'h0000);
    setup(TF_DIRECT, OF_BGRA8, 1'b0, 13'd0, 3'd0, 3'd0);
    send_texture(32'h0000_83E0, 16'h0000);
    // spare packing code falls back to RGB6A5
    setup(TF_DIRECT, OF_SPARE, 1'b0, 13'd0, 3'd0, 3'd0);
    send_texture(32'h0000_FFFF, 16'h0000);
    // alpha expansion at both ends, largest texture
    setup(TF_A3I5, OF_RGBA8, 1'b0, 13'd0, 3'd7, 3'd7);
    send_texture(32'h0000_0000, 16'h0000);
    send_texture(32'hFFFF_FFFF, 16'h0000);
    setup(TF_A5I3, OF_RGBA8, 1'b0, 13'h1FFF, 3'd7, 3'd7);
    send_texture(32'h0000_0000, 16'h0000);
    send_texture(32'h0000_00FF, 16'h0000);
    // paletted with index zero transparent; the 256-color top base wraps the address
    setup(TF_PAL4, OF_RGB6A5, 1'b1, 13'h1FFF, 3'd0, 3'd0);
    send_texture(32'h0000_00E4, 16'h0000);
    send_texture(32'h0000_0000, 16'h0000);
    setup(TF_PAL16, OF_BGRA8, 1'b1, 13'd0, 3'd0, 3'd0);
    send_texture(32'h0000_0010, 16'h0000);
    send_texture(32'h0000_00FF, 16'h0000);
    setup(TF_PAL256, OF_RGBA8, 1'b0, 13'h1FFF, 3'd0, 3'd0);
    send_texture(32'h0000_0000, 16'h0000);
    send_texture(32'h0000_00FF, 16'h0000);
    // compressed: every mode, all four color slots, top offset, row wrap
    setup(TF_BLOCK, OF_RGBA8, 1'b0, 13'h1FFF, 3'd0, 3'd0);
    send_texture(32'hE4E4_E4E4, {BLK_MODE_PAL3T, 14'h3FFF});
    send_texture(32'hE4E4_E4E4, {BLK_MODE_AVG3T, 14'h3FFF});
    send_texture(32'hE4E4_E4E4, {BLK_MODE_PAL4, 14'h3FFF});
    send_texture(32'hE4E4_E4E4, {BLK_MODE_BLEND, 14'h3FFF});
    // no format selected: texture beats are dropped
    setup(TF_NONE, OF_RGB6A5, 1'b0, 13'd0, 3'd0, 3'd0);
    send_texture(32'hFFFF_FFFF, 16'hFFFF);
    send_texture(32'h0000_0000, 16'h0000);

    // ---- random phases ----
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0:       tf = TF_DIRECT;
        1:       tf = TF_A3I5;
        2:       tf = TF_PAL4;
        3:       tf = TF_PAL16;
        4:       tf = TF_PAL256;
        5:       tf = TF_BLOCK;
        6:       tf = TF_A5I3;
        7:       tf = TF_NONE;
        default: tf = 3'($urandom_range(1, 7));
      endcase
      if (p == 0) pb = '0;
      else if (p == 1) pb = 13'h1FFF;
      else pb = 13'($urandom);
      if (p == 2) begin
        wc = 3'd7;
        hc = 3'd7;
      end else if (p % 3 == 0) begin
        wc = 3'd0;
        hc = 3'd0;
      end else begin
        wc = 3'($urandom_range(0, 3));
        hc = 3'($urandom_range(0, 3));
      end
      setup(tf, 2'(p), 1'($urandom), pb, wc, hc);
      calm = (p % 4 == 3) || (p == 5);
      // First compressed phase: hold the receiver off while beats keep coming.
      if (p == 5) long_hold_req = 1'b1;

      for (int n = 0; n < PHASE_BEATS; n++) begin
        if (!calm) tx_gap(pick_gap());
        r = $urandom_range(0, 99);
        if (r < 4) begin
          drain();
        end else if (r < 25) begin
          send_palette((r < 15) ? near_entry() : 16'($urandom), 16'($urandom));
        end else if (cur_tf == TF_BLOCK) begin
          aux = ($urandom_range(0, 7) == 0) ? 16'($urandom)
                                            : (16'($urandom) & 16'hC003);
          // now and then rewrite the block's own palette slots first
          if ($urandom_range(0, 3) == 0) begin
            for (int e = 0; e < 4; e++)
              send_palette(16'(int'(cur_pb) * 8 + int'(aux[13:0]) * 2 + e),
                           16'($urandom));
          end
          send_texture($urandom, aux);
        end else begin
          send_texture(narrow_data($urandom), 16'($urandom));
        end
      end
    end

    drain();
    if (fails == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
